// ----- src/rpch_pkg.sv -----
`default_nettype none
package rpch_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CHECK,
		ST_SCALE,
		ST_DIV,
		ST_DIST,
		ST_OUT
	} state_t;

	// register indexes of the configuration port
	localparam logic [1:0] REG_START_X = 2'd0;
	localparam logic [1:0] REG_START_Y = 2'd1;
	localparam logic [1:0] REG_END_X   = 2'd2;
	localparam logic [1:0] REG_END_Y   = 2'd3;

endpackage
`default_nettype wire

// ----- src/rpch_if.sv -----
`default_nettype none
interface rpch_if #(
	parameter int W = 33
) (
	input wire logic clk
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, input ready, output data);
	modport sink (input valid, output ready, input data);
endinterface
`default_nettype wire

// ----- src/rpch_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle, with round half away from zero
// applied to base +/- (num / den).
module rpch_div #(
	parameter int NW = 70,
	parameter int DW = 35,
	parameter int CW = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [NW-1:0]        num,
	input  wire logic [DW-1:0]        den,
	input  wire logic                 neg,
	input  wire logic signed [CW+1:0] base,
	output logic                      done,
	output logic signed [CW+1:0]      result
);
	localparam int CNTW = $clog2(NW + 1);

	logic [NW-1:0]   quo_q;
	logic [DW:0]     rem_q;
	logic [DW-1:0]   den_q;
	logic            neg_q;
	logic signed [CW+1:0] base_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic [DW:0]     shifted;
	logic [DW:0]     diff;
	logic signed [CW+1:0] q_sig;
	logic signed [CW+1:0] b;
	logic            away;
	logic            up;
	logic [DW+1:0]   twice_r;

	assign shifted = {rem_q[DW-1:0], quo_q[NW-1]};
	assign diff    = shifted - {1'b0, den_q};

	// step one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= num;
			rem_q  <= '0;
			den_q  <= den;
			neg_q  <= neg;
			base_q <= base;
		end else if (busy_q) begin
			if (!diff[DW]) begin
				rem_q <= diff;
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	// round the quotient half away from zero around the base
	always_comb begin
		q_sig   = (CW+2)'(quo_q);
		twice_r = {rem_q, 1'b0};
		b       = neg_q ? base_q - q_sig : base_q + q_sig;
		away    = neg_q ? (b <= 0) : (b >= 0);
		if (rem_q == '0)
			up = 1'b0;
		else if (away)
			up = twice_r >= {2'b00, den_q};
		else
			up = twice_r > {2'b00, den_q};
		result = neg_q ? b - (CW+2)'(up) : b + (CW+2)'(up);
	end
endmodule
`default_nettype wire

// ----- src/rpch_mul.sv -----
`default_nettype none
// Shared signed multiplier with a registered product.
module rpch_mul #(
	parameter int AW = 35,
	parameter int BW = 35
) (
	input  wire logic                    clk,
	input  wire logic signed [AW-1:0]    a,
	input  wire logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0]      p
);
	always_ff @(posedge clk) begin
		p <= a * b;
	end
endmodule
`default_nettype wire

// ----- src/ray_polyline_closest_hit_core.sv -----
`default_nettype none
// Ray versus polyline closest hit. Vertices arrive one per transaction; each
// vertex after the first closes a segment that is tested against the ray set
// in the four coordinate registers. The block is not ready while it works. A
// vertex whose segment hits keeps it busy through the products for the
// denominator and the two numerators on the one shared multiplier, a range
// check, then per hit coordinate one scaling product and a pass of the shared
// bit-serial divider over 3*COORD_BITS+5 quotient bits, and the squared
// distance. A segment that misses stops after the range check; the first
// vertex of a polyline is only stored. On the vertex flagged last one result is
// offered on the output channel; input stays closed until it is taken, then all
// polyline state is cleared.
module ray_polyline_closest_hit_core #(
	parameter int COORD_BITS = 16,
	parameter int INDEX_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [COORD_BITS-1:0] cfg_data,
	rpch_if.sink                       vin,
	rpch_if.source                     vout
);
	localparam int C   = COORD_BITS;
	localparam int DW  = 2 * C + 3;
	localparam int BW  = C + 2;
	localparam int NW  = DW + BW;
	localparam logic [INDEX_BITS-1:0] IMAX = '1;

	rpch_pkg::state_t state_q, state_d;

	logic signed [C-1:0] rsx_q, rsy_q, rex_q, rey_q;
	logic signed [C-1:0] px_q, py_q, cx_q, cy_q;
	logic                have_prev_q, last_q, any_hit_q, axis_q;
	logic signed [C-1:0] bx_q, by_q, b0_q, b1_q, b2_q, b3_q;
	logic [2*C+3:0]      bdist_q, dist_q;
	logic [INDEX_BITS-1:0] cnt_q, bidx_q, idx_q;
	logic [3:0]          step_q;
	logic signed [DW-1:0] den_q, tn_q, un_q, acc_q;
	logic signed [C+1:0] hx_q, hy_q;

	logic signed [DW-1:0] ma;
	logic signed [BW-1:0] mb;
	logic signed [NW-1:0] mp;
	logic signed [DW-1:0] mp_n;
	logic                div_start, div_done;
	logic [NW-1:0]       div_num;
	logic [DW-1:0]       div_den;
	logic                div_neg;
	logic signed [C+1:0] div_base, div_res;

	logic signed [C+1:0] dx1, dy1, ax, ay, bxv, byv, mdx, mdy, exv, eyv;
	logic signed [DW-1:0] den_n, tn_n, un_n;
	logic                miss;
	logic [2*C+3:0]      dist_sum;

	assign mp_n     = DW'(mp);
	assign dist_sum = dist_q + (2*C+4)'($unsigned(mp));

	// coordinate differences, one bit of headroom
	always_comb begin
		dx1 = (C+2)'(rex_q) - (C+2)'(rsx_q);
		dy1 = (C+2)'(rey_q) - (C+2)'(rsy_q);
		ax  = (C+2)'(px_q) - (C+2)'(cx_q);
		ay  = (C+2)'(py_q) - (C+2)'(cy_q);
		bxv = (C+2)'(rsx_q) - (C+2)'(px_q);
		byv = (C+2)'(rsy_q) - (C+2)'(py_q);
		mdx = dx1[C+1] ? -dx1 : dx1;
		mdy = dy1[C+1] ? -dy1 : dy1;
		exv = hx_q - (C+2)'(rsx_q);
		eyv = hy_q - (C+2)'(rsy_q);
	end

	// make the denominator positive and test both parameters against [0,1]
	always_comb begin
		den_n = den_q[DW-1] ? -den_q : den_q;
		tn_n  = den_q[DW-1] ? -tn_q : tn_q;
		un_n  = den_q[DW-1] ? -un_q : un_q;
		miss  = (den_q == '0) || (tn_n < 0) || (tn_n > den_n) || (un_n < 0) ||
			(un_n > den_n);
	end

	rpch_mul #(.AW(DW), .BW(BW)) u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

	rpch_div #(.NW(NW), .DW(DW), .CW(C)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.neg(div_neg), .base(div_base), .done(div_done), .result(div_res)
	);

	// operand select for the shared multiplier by state and step
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			rpch_pkg::ST_MUL:
				case (step_q)
					4'd0: begin ma = DW'(-dx1); mb = ay; end
					4'd1: begin ma = DW'(-dy1); mb = ax; end
					4'd2: begin ma = DW'(bxv); mb = ay; end
					4'd3: begin ma = DW'(byv); mb = ax; end
					4'd4: begin ma = DW'(dx1); mb = byv; end
					4'd5: begin ma = DW'(dy1); mb = bxv; end
					default: ;
				endcase
			rpch_pkg::ST_SCALE: begin
				ma = tn_q;
				mb = axis_q ? mdy : mdx;
			end
			rpch_pkg::ST_DIST:
				case (step_q)
					4'd0: begin ma = DW'(exv); mb = exv; end
					4'd1: begin ma = DW'(eyv); mb = eyv; end
					default: ;
				endcase
			default: ;
		endcase
	end

	// divider operands: |tn * delta| / den around the ray start
	always_comb begin
		div_neg  = axis_q ? dy1[C+1] : dx1[C+1];
		div_base = axis_q ? (C+2)'(rsy_q) : (C+2)'(rsx_q);
		div_num  = $unsigned(mp);
		div_den  = $unsigned(den_q);
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		case (state_q)
			rpch_pkg::ST_IDLE:
				if (vin.valid) state_d = rpch_pkg::ST_MUL;
			rpch_pkg::ST_MUL:
				if (!have_prev_q) state_d = last_q ? rpch_pkg::ST_OUT : rpch_pkg::ST_IDLE;
				else if (step_q == 4'd6) state_d = rpch_pkg::ST_CHECK;
			rpch_pkg::ST_CHECK:
				if (miss) state_d = last_q ? rpch_pkg::ST_OUT : rpch_pkg::ST_IDLE;
				else state_d = rpch_pkg::ST_SCALE;
			rpch_pkg::ST_SCALE:
				if (step_q == 4'd1) begin
					state_d   = rpch_pkg::ST_DIV;
					div_start = 1'b1;
				end
			rpch_pkg::ST_DIV:
				if (div_done) state_d = axis_q ? rpch_pkg::ST_DIST : rpch_pkg::ST_SCALE;
			rpch_pkg::ST_DIST:
				if (step_q == 4'd2) state_d = last_q ? rpch_pkg::ST_OUT : rpch_pkg::ST_IDLE;
			rpch_pkg::ST_OUT:
				if (vout.ready) state_d = rpch_pkg::ST_IDLE;
			default: state_d = rpch_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rpch_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	assign vin.ready  = (state_q == rpch_pkg::ST_IDLE);
	assign vout.valid = (state_q == rpch_pkg::ST_OUT);
	assign vout.data  = any_hit_q ?
		{1'b1, bx_q, by_q, b0_q, b1_q, b2_q, b3_q, bidx_q} : '0;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsx_q <= '0; rsy_q <= '0; rex_q <= '0; rey_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rpch_pkg::REG_START_X: rsx_q <= cfg_data;
				rpch_pkg::REG_START_Y: rsy_q <= cfg_data;
				rpch_pkg::REG_END_X:   rex_q <= cfg_data;
				rpch_pkg::REG_END_Y:   rey_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer datapath and polyline state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0; any_hit_q <= 1'b0; cnt_q <= '0; bidx_q <= '0;
			px_q <= '0; py_q <= '0; bx_q <= '0; by_q <= '0;
			b0_q <= '0; b1_q <= '0; b2_q <= '0; b3_q <= '0; bdist_q <= '0;
			step_q <= '0; last_q <= 1'b0; axis_q <= 1'b0;
			cx_q <= '0; cy_q <= '0; idx_q <= '0;
			den_q <= '0; tn_q <= '0; un_q <= '0; acc_q <= '0;
			hx_q <= '0; hy_q <= '0; dist_q <= '0;
		end else begin
			case (state_q)
				rpch_pkg::ST_IDLE: begin
					step_q <= '0;
					axis_q <= 1'b0;
					if (vin.valid) begin
						cx_q   <= vin.data[2*C:C+1];
						cy_q   <= vin.data[C:1];
						last_q <= vin.data[0];
					end
				end
				rpch_pkg::ST_MUL: begin
					step_q <= step_q + 1'b1;
					// products land in the cycle after their operands
					case (step_q)
						4'd1: acc_q <= mp_n;
						4'd2: den_q <= acc_q - mp_n;
						4'd3: acc_q <= mp_n;
						4'd4: tn_q <= acc_q - mp_n;
						4'd5: acc_q <= mp_n;
						4'd6: un_q <= acc_q - mp_n;
						default: ;
					endcase
					if (!have_prev_q) begin
						px_q <= cx_q; py_q <= cy_q; have_prev_q <= 1'b1;
					end else if (step_q == 4'd6) begin
						idx_q <= cnt_q;
						if (cnt_q != IMAX) cnt_q <= cnt_q + 1'b1;
					end
				end
				rpch_pkg::ST_CHECK: begin
					step_q <= '0;
					den_q <= den_n; tn_q <= tn_n; un_q <= un_n;
					if (miss) begin
						px_q <= cx_q; py_q <= cy_q;
					end
				end
				rpch_pkg::ST_SCALE:
					step_q <= step_q + 1'b1;
				rpch_pkg::ST_DIV: begin
					step_q <= '0;
					if (div_done) begin
						if (axis_q) hy_q <= div_res;
						else hx_q <= div_res;
						axis_q <= 1'b1;
					end
				end
				rpch_pkg::ST_DIST: begin
					step_q <= step_q + 1'b1;
					if (step_q == 4'd1) dist_q <= (2*C+4)'($unsigned(mp));
					// keep the earlier hit on a tie
					if (step_q == 4'd2) begin
						if (!any_hit_q || dist_sum < bdist_q) begin
							any_hit_q <= 1'b1; bdist_q <= dist_sum;
							bx_q <= C'(hx_q); by_q <= C'(hy_q);
							b0_q <= px_q; b1_q <= py_q; b2_q <= cx_q; b3_q <= cy_q;
							bidx_q <= idx_q;
						end
						px_q <= cx_q; py_q <= cy_q;
					end
				end
				rpch_pkg::ST_OUT:
					if (vout.ready) begin
						have_prev_q <= 1'b0; any_hit_q <= 1'b0; cnt_q <= '0; bidx_q <= '0;
						px_q <= '0; py_q <= '0; bx_q <= '0; by_q <= '0;
						b0_q <= '0; b1_q <= '0; b2_q <= '0; b3_q <= '0; bdist_q <= '0;
					end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- src/rpch_checker.sv -----
`default_nettype none
module rpch_checker #(
	parameter int OW = 113
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_ready,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire logic [OW-1:0] out_data
);
	// no new vertex while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input open with result pending");
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped or changed");
	// a miss reports all zero
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data[OW-1] |-> out_data == '0) else $error("miss not zero");
	// a taken vertex leaves input closed in the cycle after
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("input taken twice");
endmodule

bind ray_polyline_closest_hit_core rpch_checker #(
	.OW(1 + 6 * COORD_BITS + INDEX_BITS)
) u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(vin.valid), .in_ready(vin.ready),
	.out_valid(vout.valid), .out_ready(vout.ready), .out_data(vout.data)
);
`default_nettype wire
